@@ hdl/u2u_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the UTF-8 to UTF-16 decoder.
// No dependencies; every other file of the decoder imports this package.
package u2u_pkg;

    // Field widths of the stream channels.
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 21;
    localparam int M_TDATA_W   = 24;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Lead byte patterns, as prefix masks and prefix values.
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;

    // Fixed upper bits of the two surrogate halves (0xD800 and 0xDC00).
    localparam logic [4:0] SURR_HI_TAG = 5'b11011;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;

    // Class of a byte seen outside a multibyte sequence.
    typedef enum logic [1:0] {
        CLS_SINGLE,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4
    } byte_class_t;

    // One decoded value on its way from the front end to the output stage.
    typedef struct packed {
        logic              pair;   // emit as a high and a low surrogate
        logic [CODE_W-1:0] value;  // code point or passed-through byte
    } entry_t;

    // Sort a byte outside a sequence into lead kinds or a plain byte.
    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        cls = CLS_SINGLE;
        if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            cls = CLS_LEAD4;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            cls = CLS_LEAD3;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            cls = CLS_LEAD2;
        end
        return cls;
    endfunction

    // High surrogate: plane minus one in bits 10:6, value bits 15:10 below.
    function automatic logic [CODE_W-1:0] surr_hi(input logic [CODE_W-1:0] v);
        logic [4:0] plane_m1;
        plane_m1 = v[20:16] - 5'd1;
        return {5'd0, SURR_HI_TAG, plane_m1, v[15:10]};
    endfunction

    // Low surrogate: the ten lowest value bits.
    function automatic logic [CODE_W-1:0] surr_lo(input logic [CODE_W-1:0] v);
        return {5'd0, SURR_LO_TAG, v[9:0]};
    endfunction

endpackage

@@ hdl/utf8_to_utf16_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 decoder: mode register, front end, queue
// and output stage. Depends on u2u_pkg, u2u_front, u2u_fifo and u2u_back.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata[7:0] in_byte
//  m_       out        m_tvalid / m_tready  m_tdata[20:0] code_unit, m_tlast last_of_run
//  cfg_     in         cfg_wr_en            cfg_wr_data sixteen_bit_units
//
// One byte is accepted per cycle while the queue has room. A result passes
// through the queue and then the output register before it shows on m_tvalid.
// A surrogate pair occupies the output register one half after the other.
// A pair needs four input bytes, so the output stage keeps up with one byte per
// cycle whenever m_tready stays high.
// The queue holds FIFO_DEPTH entries, letting input and output stall independently.
// Reset (synchronous, active low) clears the open sequence, the queue and the
// output register, and sets sixteen_bit_units to 1.
module utf8_to_utf16_decoder #(
    parameter int FIFO_DEPTH = u2u_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,  // sixteen_bit_units
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u2u_pkg::BYTE_W-1:0]    s_tdata,      // [7:0] in_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u2u_pkg::M_TDATA_W-1:0] m_tdata,      // [20:0] code_unit, [23:21] zero
    output logic                          m_tlast       // last_of_run
);
    import u2u_pkg::*;

    logic   sixteen_bit_units_reg;
    logic   q_full, q_push, q_pop, q_not_empty;
    entry_t push_entry, head_entry;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sixteen_bit_units_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            sixteen_bit_units_reg <= cfg_wr_data;
        end
    end

    u2u_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .sixteen_bit_units (sixteen_bit_units_reg),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (push_entry)
    );

    u2u_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    u2u_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ hdl/u2u_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts UTF-8 bytes, tracks the open sequence and pushes
// finished values into the queue. Depends on u2u_pkg.
module u2u_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        sixteen_bit_units,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [u2u_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                        q_full,
    output logic                        q_push,
    output u2u_pkg::entry_t             q_entry
);
    import u2u_pkg::*;

    logic [1:0]        pending_count_reg, pending_count_next;
    logic [CODE_W-1:0] partial_value_reg, partial_value_next;
    logic              accept;
    logic [CODE_W-1:0] merged;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign merged   = {partial_value_reg[CODE_W-7:0], s_tdata[5:0]};

    // Sequence tracking and queue push for each accepted byte.
    always_comb begin
        pending_count_next = pending_count_reg;
        partial_value_next = partial_value_reg;
        q_push             = 1'b0;
        q_entry.pair       = 1'b0;
        q_entry.value      = {{(CODE_W-BYTE_W){1'b0}}, s_tdata};
        if (accept) begin
            if (pending_count_reg == 2'd0) begin
                unique case (classify(s_tdata))
                    CLS_LEAD4: begin
                        pending_count_next = 2'd3;
                        partial_value_next = {{(CODE_W-3){1'b0}}, s_tdata[2:0]};
                    end
                    CLS_LEAD3: begin
                        pending_count_next = 2'd2;
                        partial_value_next = {{(CODE_W-4){1'b0}}, s_tdata[3:0]};
                    end
                    CLS_LEAD2: begin
                        pending_count_next = 2'd1;
                        partial_value_next = {{(CODE_W-5){1'b0}}, s_tdata[4:0]};
                    end
                    default: begin
                        // Plain or stray byte outside a sequence passes through.
                        partial_value_next = '0;
                        q_push             = 1'b1;
                    end
                endcase
            end else begin
                pending_count_next = pending_count_reg - 2'd1;
                if (pending_count_reg == 2'd1) begin
                    // Last continuation byte: the code point is complete.
                    partial_value_next = '0;
                    q_push             = 1'b1;
                    q_entry.value      = merged;
                    q_entry.pair       = sixteen_bit_units && (merged[20:16] != 5'd0);
                end else begin
                    partial_value_next = merged;
                end
            end
        end
    end

    // Sequence state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_count_reg <= 2'd0;
            partial_value_reg <= '0;
        end else begin
            pending_count_reg <= pending_count_next;
            partial_value_reg <= partial_value_next;
        end
    end

endmodule

@@ hdl/u2u_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of decoded entries between the front end and the output stage.
// Depends on u2u_pkg for the entry type.
module u2u_fifo #(
    parameter int DEPTH = u2u_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u2u_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output u2u_pkg::entry_t head_entry
);
    import u2u_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/u2u_back.sv @@
`timescale 1ns / 1ps
// Output stage: pops queued entries and emits one code unit or a surrogate
// pair through an output register. Depends on u2u_pkg.
module u2u_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  u2u_pkg::entry_t               q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u2u_pkg::M_TDATA_W-1:0] m_tdata,   // [20:0] code_unit, rest zero
    output logic                          m_tlast    // last_of_run
);
    import u2u_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_unit_reg, out_unit_next;
    logic              out_last_reg, out_last_next;
    logic              lo_pending_reg, lo_pending_next;
    logic [CODE_W-1:0] lo_unit_reg, lo_unit_next;
    logic              load;

    // The output register takes a new unit when empty or when its transfer completes.
    assign load = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        lo_pending_next = lo_pending_reg;
        lo_unit_next    = lo_unit_reg;
        q_pop           = 1'b0;
        if (load) begin
            if (lo_pending_reg) begin
                // Second half of a surrogate pair.
                out_valid_next  = 1'b1;
                out_unit_next   = lo_unit_reg;
                out_last_next   = 1'b1;
                lo_pending_next = 1'b0;
            end else if (q_not_empty) begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                if (q_entry.pair) begin
                    out_unit_next   = surr_hi(q_entry.value);
                    out_last_next   = 1'b0;
                    lo_pending_next = 1'b1;
                    lo_unit_next    = surr_lo(q_entry.value);
                end else begin
                    out_unit_next = q_entry.value;
                    out_last_next = 1'b1;
                end
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            lo_pending_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            lo_pending_reg <= lo_pending_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
        lo_unit_reg  <= lo_unit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CODE_W){1'b0}}, out_unit_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/sv/u2u_checker.sv @@
`timescale 1ns / 1ps
// Checker for the UTF-8 to UTF-16 decoder: tracks the mode register, predicts the
// code units of every byte transfer and compares them with the result channel.
// Depends on u2u_pkg for widths and the byte class enum.
module u2u_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [u2u_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [u2u_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            units_waiting,
    output logic                          seq_open
);
    import u2u_pkg::*;

    localparam logic [31:0] HI_SURR_BASE = 32'hD800;
    localparam logic [31:0] LO_SURR_BASE = 32'hDC00;
    localparam logic [31:0] BMP_MAX      = 32'hFFFF;
    localparam int          REPORT_MAX   = 10;

    // One code unit as it should appear on the result channel.
    typedef struct packed {
        logic [CODE_W-1:0] cu;
        logic              last;
    } code_unit_t;

    code_unit_t        units_due[$];
    logic              split_pairs;
    logic [1:0]        cont_left;
    logic [CODE_W-1:0] gathered;

    // Sort a byte seen outside a sequence by its prefix.
    function automatic byte_class_t lead_kind(input logic [7:0] b);
        byte_class_t kind;
        casez (b)
            8'b11110???: kind = CLS_LEAD4;
            8'b1110????: kind = CLS_LEAD3;
            8'b110?????: kind = CLS_LEAD2;
            default:     kind = CLS_SINGLE;
        endcase
        return kind;
    endfunction

    // Append one expected code unit at the tail of the queue.
    task automatic queue_unit(input logic [CODE_W-1:0] cu, input logic last);
        code_unit_t u;
        u.cu   = cu;
        u.last = last;
        units_due.insert(units_due.size(), u);
    endtask

    // Advance the decode state by one byte and queue the code units it completes.
    task automatic decode_byte(input logic [7:0] b);
        logic [CODE_W-1:0] cp;
        logic [31:0]       plane_m1;
        logic [31:0]       hi_half;
        logic [31:0]       lo_half;
        if (cont_left == 2'd0) begin
            case (lead_kind(b))
                CLS_LEAD4: begin
                    cont_left = 2'd3;
                    gathered  = CODE_W'(b[2:0]);
                end
                CLS_LEAD3: begin
                    cont_left = 2'd2;
                    gathered  = CODE_W'(b[3:0]);
                end
                CLS_LEAD2: begin
                    cont_left = 2'd1;
                    gathered  = CODE_W'(b[4:0]);
                end
                default: begin
                    // Plain or stray byte: passed on, zero extended.
                    gathered = '0;
                    queue_unit(CODE_W'(b), 1'b1);
                end
            endcase
        end else begin
            // The top two bits are not checked; six payload bits are taken as they are.
            cp        = {gathered[CODE_W-7:0], b[5:0]};
            gathered  = cp;
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                gathered = '0;
                if (split_pairs && 32'(cp) > BMP_MAX) begin
                    plane_m1 = 32'(cp[20:16]) - 32'd1;
                    hi_half  = HI_SURR_BASE | ((plane_m1 << 6) & BMP_MAX) | 32'(cp[15:10]);
                    lo_half  = LO_SURR_BASE | 32'(cp[9:0]);
                    queue_unit(hi_half[CODE_W-1:0], 1'b0);
                    queue_unit(lo_half[CODE_W-1:0], 1'b1);
                end else begin
                    queue_unit(cp, 1'b1);
                end
            end
        end
    endtask

    // Compare one result transfer with the oldest waiting code unit.
    task automatic check_result();
        code_unit_t want;
        if (units_due.size() == 0) begin
            if (mismatches < REPORT_MAX) begin
                $display("%0t: unexpected result %h last %b", $realtime, m_tdata, m_tlast);
            end
            mismatches++;
        end else begin
            want = units_due.pop_front();
            if (m_tdata !== {{(M_TDATA_W-CODE_W){1'b0}}, want.cu} || m_tlast !== want.last) begin
                if (mismatches < REPORT_MAX) begin
                    $display("%0t: code unit mismatch: expected %h last %b, got %h last %b",
                             $realtime, want.cu, want.last, m_tdata, m_tlast);
                end
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        units_waiting = 0;
        seq_open      = 1'b0;
        split_pairs   = 1'b1;
        cont_left     = 2'd0;
        gathered      = '0;
    end

    // Watch both channels and the mode register at every rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            split_pairs = 1'b1;
            cont_left   = 2'd0;
            gathered    = '0;
            units_due.delete();
        end else begin
            if (cfg_wr_en) begin
                split_pairs = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        units_waiting = units_due.size();
        seq_open      = (cont_left != 2'd0);
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, byte stimulus,
// mode changes and the verdict. Depends on u2u_pkg, u2u_checker and the decoder.
module tb_top;
    import u2u_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 300;
    localparam int PHASE_COUNT  = 5;
    localparam int SETTLE_TICKS = 20;
    localparam int IDLE_PERCENT = 30;

    // Hand-picked bytes: extremes, stray bytes, every sequence length, surrogates
    // for the last valid and the largest 21-bit value, overlong and bad continuation.
    localparam logic [7:0] TOUR_BYTES [0:25] = '{
        8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hC0, 8'h80,
        8'hC3, 8'h41
    };

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic                   cfg_wr_data = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    int   mismatches;
    int   units_waiting;
    logic seq_open;
    int   bytes_sent = 0;
    int   cycles     = 0;
    bit   src_idle   = 1'b1;
    bit   snk_idle   = 1'b1;

    utf8_to_utf16_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    u2u_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .units_waiting (units_waiting),
        .seq_open      (seq_open)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: stall at random while idling is enabled.
    always @(negedge aclk) begin
        m_tready <= snk_idle ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end

    // Offer one byte, with random gaps ahead of it while idling is enabled, and return after its transfer.
    task automatic push_byte(input logic [7:0] b);
        if (src_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Mostly well-formed characters of every length with random payload, plus
    // stray bytes, arbitrary bytes and sequences broken by a wrong follower.
    task automatic push_symbol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            push_byte({1'b0, 7'($urandom)});
        end else if (pick < 40) begin
            push_byte({3'b110, 5'($urandom)});
            push_byte(cont_byte());
        end else if (pick < 60) begin
            push_byte({4'b1110, 4'($urandom)});
            repeat (2) push_byte(cont_byte());
        end else if (pick < 82) begin
            push_byte({5'b11110, 3'($urandom)});
            repeat (3) push_byte(cont_byte());
        end else if (pick < 88) begin
            push_byte(8'($urandom_range(255)));
        end else if (pick < 94) begin
            push_byte(cont_byte());
        end else begin
            push_byte({4'b1110, 4'($urandom)});
            push_byte(8'($urandom_range(255)));
            push_byte(8'($urandom_range(255)));
        end
    endtask

    // Close any open sequence, then wait for every code unit and a quiet spell.
    task automatic drain();
        while (seq_open) push_byte(cont_byte());
        s_tvalid <= 1'b0;
        while (units_waiting != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_mode(input logic split);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= split;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int phase_start;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed bytes in the reset mode, which splits into surrogates.
        foreach (TOUR_BYTES[i]) push_byte(TOUR_BYTES[i]);
        drain();

        // Random phases alternate the mode; the middle one runs without stalls.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_mode(phase % 2 == 1);
            src_idle    = (phase != 2);
            snk_idle    = (phase != 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) push_symbol();
            drain();
        end

        if (mismatches == 0 && units_waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/u2u_pkg.sv
hdl/u2u_front.sv
hdl/u2u_fifo.sv
hdl/u2u_back.sv
hdl/utf8_to_utf16_decoder.sv
tb/sv/u2u_checker.sv
tb/sv/tb_top.sv
